>>> hw/rtl/pbs_pkg.sv
// ----------------------------------------------------------------------------
// pbs_pkg
// Shared constants and types of the polyline budget split unit.
// ----------------------------------------------------------------------------
package pbs_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int TOTAL_WIDTH     = 40;
    localparam int BUDGET_WIDTH    = 32;
    localparam int QUEUE_DEPTH     = 2;

    // operations of the serial arithmetic unit
    typedef enum logic [2:0] {
        OP_MUL  = 3'b001,
        OP_SQRT = 3'b010,
        OP_DIV  = 3'b100
    } t_op;

    typedef struct packed {
        logic go;
        t_op  op;
    } t_arith_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_arith_sts;

endpackage

>>> hw/rtl/pbs_point_if.sv
// ----------------------------------------------------------------------------
// pbs_point_if
// Path point request channel.
// ----------------------------------------------------------------------------
interface pbs_point_if #(
    parameter int COORD_WIDTH = pbs_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic                          starts_path;

    modport source (output valid, point_x, point_y, point_z, starts_path, input ready);
    modport sink   (input valid, point_x, point_y, point_z, starts_path, output ready);
endinterface

>>> hw/rtl/pbs_result_if.sv
// ----------------------------------------------------------------------------
// pbs_result_if
// Emitted point request channel.
// ----------------------------------------------------------------------------
interface pbs_result_if #(
    parameter int COORD_WIDTH = pbs_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic signed [COORD_WIDTH-1:0] out_z;
    logic                          beyond_reach;
    logic                          last_of_run;

    modport source (output valid, out_x, out_y, out_z, beyond_reach, last_of_run,
                    input ready);
    modport sink   (input valid, out_x, out_y, out_z, beyond_reach, last_of_run,
                    output ready);
endinterface

>>> hw/rtl/pbs_cfg_if.sv
// ----------------------------------------------------------------------------
// pbs_cfg_if
// Distance budget write channel.
// ----------------------------------------------------------------------------
interface pbs_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [pbs_pkg::BUDGET_WIDTH-1:0]    distance_budget;

    modport source (output valid, distance_budget, input ready);
    modport sink   (input valid, distance_budget, output ready);
endinterface

>>> hw/rtl/pbs_queue.sv
// ----------------------------------------------------------------------------
// pbs_queue
// Short register queue between the front and back parts.
// ----------------------------------------------------------------------------
module pbs_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = pbs_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output logic             o_full,
    output logic [WIDTH-1:0] o_data
);
    localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PTRW-1:0]  r_wr, n_wr;
    logic [PTRW-1:0]  r_rd, n_rd;
    logic [CNTW-1:0]  r_cnt, n_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == CNTW'(DEPTH));
    assign o_data  = r_slot[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTRW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTRW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_data;
        end
    end
endmodule

>>> hw/rtl/pbs_front.sv
// ----------------------------------------------------------------------------
// pbs_front
// Accepts path points, forms the segment differences against the previous
// point and queues the work for the back part.
// ----------------------------------------------------------------------------
module pbs_front #(
    parameter int COORD_WIDTH = pbs_pkg::COORD_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    pbs_point_if.sink                            i_point,
    input  logic                                 i_full,
    output logic                                 o_push,
    output logic [4+9*COORD_WIDTH+2:0]           o_data
);
    localparam int LW = COORD_WIDTH + 1;

    logic signed [COORD_WIDTH-1:0] r_px, r_py, r_pz;
    logic [LW-1:0] w_dx, w_dy, w_dz;
    logic [LW-1:0] w_mx, w_my, w_mz;

    assign i_point.ready = !i_full;
    assign o_push        = i_point.valid && !i_full;

    assign w_dx = {i_point.point_x[COORD_WIDTH-1], i_point.point_x} - {r_px[COORD_WIDTH-1], r_px};
    assign w_dy = {i_point.point_y[COORD_WIDTH-1], i_point.point_y} - {r_py[COORD_WIDTH-1], r_py};
    assign w_dz = {i_point.point_z[COORD_WIDTH-1], i_point.point_z} - {r_pz[COORD_WIDTH-1], r_pz};

    assign w_mx = w_dx[LW-1] ? LW'(0) - w_dx : w_dx;
    assign w_my = w_dy[LW-1] ? LW'(0) - w_dy : w_dy;
    assign w_mz = w_dz[LW-1] ? LW'(0) - w_dz : w_dz;

    assign o_data = {i_point.starts_path, w_dx[LW-1], w_dy[LW-1], w_dz[LW-1],
                     w_mx, w_my, w_mz,
                     i_point.point_x, i_point.point_y, i_point.point_z,
                     r_px, r_py, r_pz};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px <= '0;
            r_py <= '0;
            r_pz <= '0;
        end else if (o_push) begin
            r_px <= i_point.point_x;
            r_py <= i_point.point_y;
            r_pz <= i_point.point_z;
        end
    end
endmodule

>>> hw/rtl/pbs_arith.sv
// ----------------------------------------------------------------------------
// pbs_arith
// Shared bit-serial arithmetic: shift-add multiply, digit-by-digit square
// root and restoring division, one bit per cycle.
// ----------------------------------------------------------------------------
module pbs_arith #(
    parameter int COORD_WIDTH = pbs_pkg::COORD_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  pbs_pkg::t_arith_req     i_req,
    input  logic [((COORD_WIDTH+1 > pbs_pkg::BUDGET_WIDTH) ?
                   COORD_WIDTH+1 : pbs_pkg::BUDGET_WIDTH)-1:0] i_opa,
    input  logic [((COORD_WIDTH+1 > pbs_pkg::BUDGET_WIDTH) ?
                   COORD_WIDTH+1 : pbs_pkg::BUDGET_WIDTH)-1:0] i_opb,
    input  logic [2*((COORD_WIDTH+1 > pbs_pkg::BUDGET_WIDTH) ?
                   COORD_WIDTH+1 : pbs_pkg::BUDGET_WIDTH)-1:0] i_wide,
    output pbs_pkg::t_arith_sts     o_sts,
    output logic [2*((COORD_WIDTH+1 > pbs_pkg::BUDGET_WIDTH) ?
                   COORD_WIDTH+1 : pbs_pkg::BUDGET_WIDTH)-1:0] o_prod,
    output logic [COORD_WIDTH:0]    o_quo
);
    import pbs_pkg::*;

    localparam int LW   = COORD_WIDTH + 1;
    localparam int MW   = (LW > BUDGET_WIDTH) ? LW : BUDGET_WIDTH;
    localparam int PW   = 2 * MW;
    localparam int SW   = 2 * COORD_WIDTH + 2;
    localparam int NW   = LW + BUDGET_WIDTH;
    localparam int RW   = COORD_WIDTH + 4;
    localparam int CNTW = $clog2(MW + 1);

    typedef enum logic [1:0] {
        A_IDLE = 2'b01,
        A_RUN  = 2'b10
    } t_astate;

    t_astate         r_state, n_state;
    t_op             r_op, n_op;
    logic [PW-1:0]   r_p, n_p;
    logic [MW-1:0]   r_a, n_a;
    logic [RW-1:0]   r_rem, n_rem;
    logic [LW-1:0]   r_q, n_q;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic            r_done, n_done;

    logic [MW:0]     w_mul_up;
    logic [RW-1:0]   w_sq_w, w_sq_t, w_dv_w, w_dv_d;

    assign o_sts.busy = (r_state == A_RUN);
    assign o_sts.done = r_done;
    assign o_prod     = r_p;
    assign o_quo      = r_q;

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_p      = r_p;
        n_a      = r_a;
        n_rem    = r_rem;
        n_q      = r_q;
        n_cnt    = r_cnt;
        n_done   = 1'b0;
        w_mul_up = {1'b0, r_p[PW-1:MW]} + {1'b0, (r_p[0] ? r_a : {MW{1'b0}})};
        w_sq_w   = {r_rem[RW-3:0], r_p[PW-1 -: 2]};
        w_sq_t   = RW'({r_q, 2'b01});
        w_dv_w   = {r_rem[RW-2:0], r_p[PW-1]};
        w_dv_d   = RW'(r_a[LW-1:0]);
        case (r_state)
            A_IDLE: begin
                if (i_req.go) begin
                    n_state = A_RUN;
                    n_op    = i_req.op;
                    n_a     = i_opa;
                    n_q     = '0;
                    n_rem   = '0;
                    case (i_req.op)
                        OP_MUL: begin
                            n_p   = {{MW{1'b0}}, i_opb};
                            n_cnt = CNTW'(MW);
                        end
                        OP_SQRT: begin
                            n_p   = i_wide << (PW - SW);
                            n_cnt = CNTW'(LW);
                        end
                        OP_DIV: begin
                            // quotient is known to fit LW bits: seed with the top part
                            n_rem = RW'(i_wide[NW-1:LW]);
                            n_p   = i_wide << (PW - LW);
                            n_cnt = CNTW'(LW);
                        end
                        default: begin
                            n_state = A_IDLE;
                        end
                    endcase
                end
            end
            A_RUN: begin
                case (r_op)
                    OP_MUL: begin
                        n_p = {w_mul_up, r_p[MW-1:1]};
                    end
                    OP_SQRT: begin
                        n_p = r_p << 2;
                        if (w_sq_w >= w_sq_t) begin
                            n_rem = w_sq_w - w_sq_t;
                            n_q   = {r_q[LW-2:0], 1'b1};
                        end else begin
                            n_rem = w_sq_w;
                            n_q   = {r_q[LW-2:0], 1'b0};
                        end
                    end
                    OP_DIV: begin
                        n_p = r_p << 1;
                        if (w_dv_w >= w_dv_d) begin
                            n_rem = w_dv_w - w_dv_d;
                            n_q   = {r_q[LW-2:0], 1'b1};
                        end else begin
                            n_rem = w_dv_w;
                            n_q   = {r_q[LW-2:0], 1'b0};
                        end
                    end
                    default: begin
                        n_p = r_p;
                    end
                endcase
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    n_state = A_IDLE;
                    n_done  = 1'b1;
                end
            end
            default: begin
                n_state = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
            r_op    <= OP_MUL;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_cnt   <= n_cnt;
            r_op    <= n_op;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p   <= n_p;
        r_a   <= n_a;
        r_rem <= n_rem;
        r_q   <= n_q;
    end
endmodule

>>> hw/rtl/pbs_back.sv
// ----------------------------------------------------------------------------
// pbs_back
// Measures each queued segment, checks it against the budget, works out
// the crossing point and drives the result register.
// ----------------------------------------------------------------------------
module pbs_back #(
    parameter int COORD_WIDTH = pbs_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    pbs_cfg_if.sink                       i_cfg,
    input  logic                          i_q_valid,
    input  logic [4+9*COORD_WIDTH+2:0]    i_q_data,
    output logic                          o_q_pop,
    output pbs_pkg::t_arith_req           o_req,
    output logic [((COORD_WIDTH+1 > pbs_pkg::BUDGET_WIDTH) ?
                   COORD_WIDTH+1 : pbs_pkg::BUDGET_WIDTH)-1:0] o_opa,
    output logic [((COORD_WIDTH+1 > pbs_pkg::BUDGET_WIDTH) ?
                   COORD_WIDTH+1 : pbs_pkg::BUDGET_WIDTH)-1:0] o_opb,
    output logic [2*((COORD_WIDTH+1 > pbs_pkg::BUDGET_WIDTH) ?
                   COORD_WIDTH+1 : pbs_pkg::BUDGET_WIDTH)-1:0] o_wide,
    input  pbs_pkg::t_arith_sts           i_sts,
    input  logic [2*((COORD_WIDTH+1 > pbs_pkg::BUDGET_WIDTH) ?
                   COORD_WIDTH+1 : pbs_pkg::BUDGET_WIDTH)-1:0] i_prod,
    input  logic [COORD_WIDTH:0]          i_quo,
    pbs_result_if.source                  o_result
);
    import pbs_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int LW   = CW + 1;
    localparam int MW   = (LW > BUDGET_WIDTH) ? LW : BUDGET_WIDTH;
    localparam int PW   = 2 * MW;
    localparam int SW   = 2 * CW + 2;
    localparam int SUMW = ((TOTAL_WIDTH > LW) ? TOTAL_WIDTH : LW) + 1;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SQ     = 8'b0000_0010,
        S_ROOT   = 8'b0000_0100,
        S_DECIDE = 8'b0000_1000,
        S_MUL    = 8'b0001_0000,
        S_DIV    = 8'b0010_0000,
        S_OUT1   = 8'b0100_0000,
        S_OUT2   = 8'b1000_0000
    } t_state;

    // queue entry fields
    logic                 w_start;
    logic [2:0]           w_sgn;
    logic [LW-1:0]        w_mx, w_my, w_mz;
    logic signed [CW-1:0] w_x, w_y, w_z, w_px, w_py, w_pz;

    assign {w_start, w_sgn, w_mx, w_my, w_mz, w_x, w_y, w_z, w_px, w_py, w_pz} = i_q_data;

    t_state                 r_state, n_state;
    logic [1:0]             r_k, n_k;
    logic signed [CW-1:0]   r_pt  [3];
    logic signed [CW-1:0]   r_pv  [3];
    logic [LW-1:0]          r_mag [3];
    logic [2:0]             r_sgn;
    logic signed [CW-1:0]   r_cross [3];
    logic [SW-1:0]          r_sum;
    logic [LW-1:0]          r_len;
    logic [TOTAL_WIDTH-1:0] r_total;
    logic [BUDGET_WIDTH-1:0] r_rem_b;
    logic [BUDGET_WIDTH-1:0] r_budget;
    logic                   r_far;
    logic                   r_go, n_go;
    t_op                    r_op, n_op;
    logic                   r_ov;
    logic signed [CW-1:0]   r_ox, r_oy, r_oz;
    logic                   r_ob, r_ol;

    logic                   w_free;
    logic [SUMW-1:0]        w_sum;
    logic [CW-1:0]          w_q;
    logic signed [CW-1:0]   w_cross;

    assign i_cfg.ready = 1'b1;
    assign w_free      = !r_ov || o_result.ready;
    assign o_q_pop     = (r_state == S_IDLE) && i_q_valid;
    assign w_sum       = SUMW'(r_total) + SUMW'(r_len);
    assign w_q         = i_quo[CW-1:0];
    assign w_cross     = r_sgn[r_k] ? r_pv[r_k] - w_q : r_pv[r_k] + w_q;

    assign o_req.go = r_go;
    assign o_req.op = r_op;
    assign o_opa    = (r_state == S_DIV) ? MW'(r_len) : MW'(r_mag[r_k]);
    assign o_opb    = (r_state == S_MUL) ? MW'(r_rem_b) : MW'(r_mag[r_k]);
    assign o_wide   = (r_state == S_ROOT) ? PW'(r_sum) : i_prod;

    assign o_result.valid        = r_ov;
    assign o_result.out_x        = r_ox;
    assign o_result.out_y        = r_oy;
    assign o_result.out_z        = r_oz;
    assign o_result.beyond_reach = r_ob;
    assign o_result.last_of_run  = r_ol;

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_go    = 1'b0;
        n_op    = r_op;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_k     = 2'd0;
                    n_state = w_start ? S_OUT2 : S_SQ;
                    if (!w_start) begin
                        n_go = 1'b1;
                        n_op = OP_MUL;
                    end
                end
            end
            S_SQ: begin
                if (i_sts.done) begin
                    n_go = 1'b1;
                    if (r_k == 2'd2) begin
                        n_state = S_ROOT;
                        n_op    = OP_SQRT;
                    end else begin
                        n_k  = r_k + 1'b1;
                        n_op = OP_MUL;
                    end
                end
            end
            S_ROOT: begin
                if (i_sts.done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (w_sum <= SUMW'(r_budget)) begin
                    n_state = S_OUT2;
                end else if (TOTAL_WIDTH'(r_budget) <= r_total) begin
                    n_state = S_OUT2;
                end else begin
                    n_k     = 2'd0;
                    n_state = S_MUL;
                    n_go    = 1'b1;
                    n_op    = OP_MUL;
                end
            end
            S_MUL: begin
                if (i_sts.done) begin
                    n_state = S_DIV;
                    n_go    = 1'b1;
                    n_op    = OP_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.done) begin
                    if (r_k == 2'd2) begin
                        n_state = S_OUT1;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = S_MUL;
                        n_go    = 1'b1;
                        n_op    = OP_MUL;
                    end
                end
            end
            S_OUT1: begin
                if (w_free) begin
                    n_state = S_OUT2;
                end
            end
            S_OUT2: begin
                if (w_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_k      <= 2'd0;
            r_go     <= 1'b0;
            r_op     <= OP_MUL;
            r_ov     <= 1'b0;
            r_total  <= '0;
            r_budget <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_go    <= n_go;
            r_op    <= n_op;
            if (i_cfg.valid) begin
                r_budget <= i_cfg.distance_budget;
            end
            // load a new request, or drop the one taken downstream
            if ((r_state == S_OUT1 || r_state == S_OUT2) && w_free) begin
                r_ov <= 1'b1;
            end else if (o_result.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid && w_start) begin
                        r_total <= '0;
                    end
                end
                S_DECIDE: begin
                    // saturate the running total
                    if (w_sum > SUMW'({TOTAL_WIDTH{1'b1}})) begin
                        r_total <= {TOTAL_WIDTH{1'b1}};
                    end else begin
                        r_total <= w_sum[TOTAL_WIDTH-1:0];
                    end
                end
                default: begin
                    r_total <= r_total;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    r_pt[0]  <= w_x;
                    r_pt[1]  <= w_y;
                    r_pt[2]  <= w_z;
                    r_pv[0]  <= w_px;
                    r_pv[1]  <= w_py;
                    r_pv[2]  <= w_pz;
                    r_mag[0] <= w_mx;
                    r_mag[1] <= w_my;
                    r_mag[2] <= w_mz;
                    r_sgn    <= {w_sgn[0], w_sgn[1], w_sgn[2]};
                    r_sum    <= '0;
                    r_far    <= 1'b0;
                end
            end
            S_SQ: begin
                if (i_sts.done) begin
                    r_sum <= r_sum + i_prod[SW-1:0];
                end
            end
            S_ROOT: begin
                if (i_sts.done) begin
                    r_len <= i_quo;
                end
            end
            S_DECIDE: begin
                r_rem_b <= r_budget - r_total[BUDGET_WIDTH-1:0];
                r_far   <= !(w_sum <= SUMW'(r_budget));
            end
            S_DIV: begin
                if (i_sts.done) begin
                    r_cross[r_k] <= w_cross;
                end
            end
            S_OUT1: begin
                if (w_free) begin
                    r_ox <= r_cross[0];
                    r_oy <= r_cross[1];
                    r_oz <= r_cross[2];
                    r_ob <= 1'b0;
                    r_ol <= 1'b0;
                end
            end
            S_OUT2: begin
                if (w_free) begin
                    r_ox <= r_pt[0];
                    r_oy <= r_pt[1];
                    r_oz <= r_pt[2];
                    r_ob <= r_far;
                    r_ol <= 1'b1;
                end
            end
            default: begin
                r_len <= r_len;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_len != '0))
        else $error("division by a zero segment length");

    a_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.done |-> (r_state == S_SQ || r_state == S_ROOT ||
                        r_state == S_MUL || r_state == S_DIV))
        else $error("arithmetic result with no operation pending");

    a_go_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_go |-> !i_sts.busy)
        else $error("arithmetic started while busy");

    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k != 2'd3)
        else $error("axis index out of range");
`endif
endmodule

>>> hw/rtl/polyline_budget_split_unit.sv
// ----------------------------------------------------------------------------
// polyline_budget_split_unit
// Splits a 3D path at a configured travel distance.
// ----------------------------------------------------------------------------
// A later point of a path takes three squares and a square root, one bit
// per cycle on the shared serial arithmetic unit. When the budget runs
// out inside a segment, the crossing point adds one multiply and one
// divide per axis. A two-entry queue lets new points be taken while a
// segment is measured, and results wait in an output register.
module polyline_budget_split_unit #(
    parameter int COORD_WIDTH = pbs_pkg::COORD_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pbs_point_if.sink     i_point,
    pbs_cfg_if.sink       i_cfg,
    pbs_result_if.source  o_result
);
    import pbs_pkg::*;

    localparam int LW = COORD_WIDTH + 1;
    localparam int MW = (LW > BUDGET_WIDTH) ? LW : BUDGET_WIDTH;
    localparam int EW = 4 + 9 * COORD_WIDTH + 3;

    logic          w_push, w_pop, w_q_valid, w_full;
    logic [EW-1:0] w_push_data, w_q_data;
    t_arith_req    w_req;
    t_arith_sts    w_sts;
    logic [MW-1:0]   w_opa, w_opb;
    logic [2*MW-1:0] w_wide, w_prod;
    logic [LW-1:0]   w_quo;

    pbs_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_point (i_point),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_data  (w_push_data)
    );

    pbs_queue #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_full  (w_full),
        .o_data  (w_q_data)
    );

    pbs_arith #(.COORD_WIDTH(COORD_WIDTH)) u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_opa   (w_opa),
        .i_opb   (w_opb),
        .i_wide  (w_wide),
        .o_sts   (w_sts),
        .o_prod  (w_prod),
        .o_quo   (w_quo)
    );

    pbs_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (i_cfg),
        .i_q_valid (w_q_valid),
        .i_q_data  (w_q_data),
        .o_q_pop   (w_pop),
        .o_req     (w_req),
        .o_opa     (w_opa),
        .o_opb     (w_opb),
        .o_wide    (w_wide),
        .i_sts     (w_sts),
        .i_prod    (w_prod),
        .i_quo     (w_quo),
        .o_result  (o_result)
    );
endmodule
